// ----- design/apa_pkg.sv -----
package apa_pkg;

  // torque ceiling applied on top of the programmable limit, mNm
  localparam logic [15:0] HARD_TORQUE_MAX = 16'd2500;

  // register indexes of the configuration port
  typedef enum logic [2:0] {
    REG_LEFT_OFFSET     = 3'd0,
    REG_RIGHT_OFFSET    = 3'd1,
    REG_SIDE_INVERT     = 3'd2,
    REG_TRIGGER_ANGLE   = 3'd3,
    REG_REARM_ANGLE     = 3'd4,
    REG_PULSE_MS        = 3'd5,
    REG_TORQUE_LIMIT    = 3'd6,
    REG_TORQUE_REQUESTS = 3'd7
  } cfg_reg_e;

  // reset values of the configuration registers
  localparam logic [15:0] RST_TRIGGER_ANGLE   = 16'd200;
  localparam logic [15:0] RST_REARM_ANGLE     = 16'd150;
  localparam logic [15:0] RST_PULSE_MS        = 16'd120;
  localparam logic [15:0] RST_TORQUE_LIMIT    = 16'd1000;
  localparam logic [31:0] RST_TORQUE_REQUESTS = 32'd65537000;

  // per-side settings handed to a lane
  typedef struct packed {
    logic signed [15:0] offset;
    logic               invert;
    logic signed [15:0] trigger;
    logic signed [15:0] rearm;
    logic [15:0]        pulse_ms;
    logic [11:0]        limit;
    logic signed [15:0] request;
  } lane_cfg_t;

  // per-side findings returned by a lane
  typedef struct packed {
    logic signed [12:0] torque;
    logic               pulse;
    logic               over;
    logic signed [16:0] corrected;
  } lane_res_t;

endpackage

// ----- design/apa_lane.sv -----
module apa_lane (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic               gate,
  input  logic signed [15:0] raw_angle,
  input  logic [31:0]        now_ms,
  input  apa_pkg::lane_cfg_t cfg,
  output apa_pkg::lane_res_t res
);

  logic               armed;
  logic               pulse;
  logic [31:0]        start_ms;

  logic signed [16:0] corr_raw;
  logic signed [16:0] corr;
  logic signed [16:0] trig17;
  logic signed [16:0] rearm17;
  logic               over;
  logic               armed_a;
  logic               fire;
  logic [31:0]        start_eff;
  logic [31:0]        elapsed;
  logic               pulse_a;
  logic signed [16:0] req17;
  logic signed [16:0] lim17;
  logic signed [16:0] neg_lim17;
  logic signed [16:0] clamped;

  // corrected angle, optionally mirrored
  assign corr_raw = $signed({raw_angle[15], raw_angle}) - $signed({cfg.offset[15], cfg.offset});
  assign corr     = cfg.invert ? -corr_raw : corr_raw;

  assign trig17  = $signed({cfg.trigger[15], cfg.trigger});
  assign rearm17 = $signed({cfg.rearm[15], cfg.rearm});
  assign over    = corr >= trig17;

  // rearm first, then fire from the updated armed flag
  assign armed_a   = armed | (corr <= rearm17);
  assign fire      = armed_a & over;
  assign start_eff = fire ? now_ms : start_ms;
  assign elapsed   = now_ms - start_eff;
  assign pulse_a   = (pulse | fire) & (elapsed < {16'd0, cfg.pulse_ms});

  // symmetric clamp of the request
  assign req17     = $signed({cfg.request[15], cfg.request});
  assign lim17     = $signed({5'd0, cfg.limit});
  assign neg_lim17 = -lim17;

  always_comb begin
    if (req17 > lim17) begin
      clamped = lim17;
    end else if (req17 < neg_lim17) begin
      clamped = neg_lim17;
    end else begin
      clamped = req17;
    end
  end

  always_comb begin
    res.corrected = corr;
    res.over      = gate & over;
    res.pulse     = gate & pulse_a;
    res.torque    = (gate && pulse_a) ? clamped[12:0] : 13'sd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed    <= 1'b1;
      pulse    <= 1'b0;
      start_ms <= 32'd0;
    end else if (accept) begin
      if (gate) begin
        armed <= armed_a & ~fire;
        pulse <= pulse_a;
        if (fire) begin
          start_ms <= now_ms;
        end
      end else begin
        armed <= 1'b1;
        pulse <= 1'b0;
      end
    end
  end

endmodule

// ----- design/angle_triggered_assist_pulse_core.sv -----
// a result is registered and presented in the cycle after its item is accepted
// throughput: one item per cycle; in_ready drops only while a held result waits on out_ready
// rate is set by the single output register shared by both side lanes
// reset (synchronous, rst high): registers take their defaults, request and session clear,
// both sides rearm, pulses stop, and the output register empties
module angle_triggered_assist_pulse_core (
  input  logic               clk,
  input  logic               rst,
  // sample channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] left_raw_angle,
  input  logic signed [15:0] right_raw_angle,
  input  logic [31:0]        now_ms,
  input  logic               assist_mode,
  input  logic               toggle_press,
  input  logic               disable_press,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [12:0] left_torque_cmd,
  output logic signed [12:0] right_torque_cmd,
  output logic               left_pulse,
  output logic               right_pulse,
  output logic               left_over,
  output logic               right_over,
  output logic signed [16:0] left_corrected,
  output logic signed [16:0] right_corrected,
  output logic               output_enabled,
  output logic               request_flag,
  // configuration write port
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  // configuration registers
  logic [15:0] left_offset;
  logic [15:0] right_offset;
  logic [1:0]  side_invert;
  logic [15:0] trigger_angle;
  logic [15:0] rearm_angle;
  logic [15:0] pulse_ms;
  logic [15:0] torque_limit;
  logic [31:0] torque_requests;

  // session state
  logic control_request;
  logic session_active;
  logic control_request_next;
  logic session_active_next;
  logic request_base;
  logic gate;
  logic accept;

  logic [15:0]        limit_sat;
  apa_pkg::lane_cfg_t left_cfg;
  apa_pkg::lane_cfg_t right_cfg;
  apa_pkg::lane_res_t left_res;
  apa_pkg::lane_res_t right_res;

  // output register accepts a new item whenever it is empty or being drained
  assign in_ready = ~out_valid | out_ready;
  assign accept   = in_valid & in_ready;

  // configuration writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      left_offset     <= 16'd0;
      right_offset    <= 16'd0;
      side_invert     <= 2'd0;
      trigger_angle   <= apa_pkg::RST_TRIGGER_ANGLE;
      rearm_angle     <= apa_pkg::RST_REARM_ANGLE;
      pulse_ms        <= apa_pkg::RST_PULSE_MS;
      torque_limit    <= apa_pkg::RST_TORQUE_LIMIT;
      torque_requests <= apa_pkg::RST_TORQUE_REQUESTS;
    end else if (cfg_we) begin
      case (apa_pkg::cfg_reg_e'(cfg_index))
        apa_pkg::REG_LEFT_OFFSET:     left_offset     <= cfg_data[15:0];
        apa_pkg::REG_RIGHT_OFFSET:    right_offset    <= cfg_data[15:0];
        apa_pkg::REG_SIDE_INVERT:     side_invert     <= cfg_data[1:0];
        apa_pkg::REG_TRIGGER_ANGLE:   trigger_angle   <= cfg_data[15:0];
        apa_pkg::REG_REARM_ANGLE:     rearm_angle     <= cfg_data[15:0];
        apa_pkg::REG_PULSE_MS:        pulse_ms        <= cfg_data[15:0];
        apa_pkg::REG_TORQUE_LIMIT:    torque_limit    <= cfg_data[15:0];
        apa_pkg::REG_TORQUE_REQUESTS: torque_requests <= cfg_data;
        default: ;
      endcase
    end
  end

  // session and button handling
  // entering assist mode starts a fresh session with the request cleared,
  // leaving it drops the request; disable wins over toggle
  assign request_base = session_active ? control_request : 1'b0;

  always_comb begin
    control_request_next = control_request;
    session_active_next  = session_active;
    if (!assist_mode) begin
      if (session_active) begin
        control_request_next = 1'b0;
        session_active_next  = 1'b0;
      end
    end else begin
      session_active_next = 1'b1;
      if (disable_press) begin
        control_request_next = 1'b0;
      end else if (toggle_press) begin
        control_request_next = ~request_base;
      end else begin
        control_request_next = request_base;
      end
    end
  end

  // safety gate: request held and device in assist mode
  assign gate = control_request_next & assist_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      control_request <= 1'b0;
      session_active  <= 1'b0;
    end else if (accept) begin
      control_request <= control_request_next;
      session_active  <= session_active_next;
    end
  end

  // torque limit saturates at the hard ceiling
  assign limit_sat = (torque_limit > apa_pkg::HARD_TORQUE_MAX) ?
                     apa_pkg::HARD_TORQUE_MAX : torque_limit;

  always_comb begin
    left_cfg.offset    = left_offset;
    left_cfg.invert    = side_invert[0];
    left_cfg.trigger   = trigger_angle;
    left_cfg.rearm     = rearm_angle;
    left_cfg.pulse_ms  = pulse_ms;
    left_cfg.limit     = limit_sat[11:0];
    left_cfg.request   = torque_requests[15:0];

    right_cfg.offset   = right_offset;
    right_cfg.invert   = side_invert[1];
    right_cfg.trigger  = trigger_angle;
    right_cfg.rearm    = rearm_angle;
    right_cfg.pulse_ms = pulse_ms;
    right_cfg.limit    = limit_sat[11:0];
    right_cfg.request  = torque_requests[31:16];
  end

  // one lane per side, each holding its own arm / pulse / start time state
  apa_lane u_left (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .gate      (gate),
    .raw_angle (left_raw_angle),
    .now_ms    (now_ms),
    .cfg       (left_cfg),
    .res       (left_res)
  );

  apa_lane u_right (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .gate      (gate),
    .raw_angle (right_raw_angle),
    .now_ms    (now_ms),
    .cfg       (right_cfg),
    .res       (right_res)
  );

  // merge stage: both lanes plus session flags into the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      left_torque_cmd  <= left_res.torque;
      right_torque_cmd <= right_res.torque;
      left_pulse       <= left_res.pulse;
      right_pulse      <= right_res.pulse;
      left_over        <= left_res.over;
      right_over       <= right_res.over;
      left_corrected   <= left_res.corrected;
      right_corrected  <= right_res.corrected;
      output_enabled   <= gate;
      request_flag     <= control_request_next;
    end
  end

`ifndef ASSERT_OFF
  a_gate_needs_request: assert property (@(posedge clk) disable iff (rst)
    out_valid && output_enabled |-> request_flag)
    else $error("gate open without a control request");

  a_closed_gate_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && !output_enabled |->
      left_torque_cmd == 13'sd0 && right_torque_cmd == 13'sd0 &&
      !left_pulse && !right_pulse && !left_over && !right_over)
    else $error("activity while the gate is closed");

  a_left_torque_in_pulse: assert property (@(posedge clk) disable iff (rst)
    out_valid && !left_pulse |-> left_torque_cmd == 13'sd0)
    else $error("left torque outside a pulse");

  a_right_torque_in_pulse: assert property (@(posedge clk) disable iff (rst)
    out_valid && !right_pulse |-> right_torque_cmd == 13'sd0)
    else $error("right torque outside a pulse");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted item produced no result");
`endif

endmodule
